// ----- hdl/sdv_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, constants, register codes and fixed-point helpers of the sun direction core.
// Depends on nothing; used by every module of the block.
package sdv_pkg;

	// port widths
	localparam int TIME_W = 21;
	localparam int DAY_W  = 9;
	localparam int LAT_W  = 24;
	localparam int NOFF_W = 26;
	localparam int DIR_W  = 18;
	localparam int IDX_W  = 2;

	// arithmetic formats
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int ANG_W  = 28;   // degrees Q16, signed
	localparam int Q_W    = 20;   // sines, cosines and components Q16, signed
	localparam int P_W    = 48;   // product width
	localparam int Z_W    = 34;   // CORDIC residual angle, radians Q30
	localparam int SUM_W  = 36;   // sum of squares
	localparam int LEN_W  = 18;   // vector length
	localparam int QUO_W  = 17;   // quotient magnitude
	localparam int YFX_W  = 17;   // remainder term of the year angle

	// pipeline depths
	localparam int ISQ_STEPS  = LEN_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int CORDIC_LAT = CORDIC_STEPS + 3;
	localparam int ISQ_LAT    = ISQ_STEPS;
	localparam int DIV_LAT    = DIV_STEPS + 1;
	localparam int PIPE_LEN   = 9 + 2 * CORDIC_LAT + ISQ_LAT + DIV_LAT;

	// angles and time
	localparam int ONE_Q16        = 65536;
	localparam int FULL_TURN_Q16  = 23592960;
	localparam int HALF_TURN_Q16  = FULL_TURN_Q16 / 2;
	localparam int QUARTER_TURN_Q16 = FULL_TURN_Q16 / 4;
	localparam int DEG_TO_RAD_Q30 = 18740330;
	localparam int GAIN_Q30       = 652032874;
	localparam int GAIN_Q = (GAIN_Q30 + (1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
	localparam int TIME_MAX       = 1572863;
	localparam int NOON_Q16       = 12 * ONE_Q16;
	localparam int DEG_PER_HOUR   = 15;
	localparam int LAT_MAX        = 5898240;
	localparam int DECL_AMP_Q16   = 1536164;

	// day of year to angle: FULL_TURN * n / YEAR_DAYS split into whole step and remainder
	localparam int EQUINOX_DAY = 80;
	localparam int YEAR_DAYS   = 366;
	localparam int YEAR_STEP   = FULL_TURN_Q16 / YEAR_DAYS;
	localparam int YEAR_REM    = FULL_TURN_Q16 % YEAR_DAYS;
	localparam int RECIP_SH    = 25;
	localparam int YEAR_RECIP  = ((1 << RECIP_SH) + YEAR_DAYS - 1) / YEAR_DAYS;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_LATITUDE     = 2'd0,
		REG_NORTH_OFFSET = 2'd1
	} cfg_reg_t;

	// divider result
	typedef struct packed {
		logic             neg;
		logic [QUO_W-1:0] mag;
	} quo_t;

	// arctangent of 2^-i, radians Q30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h3243F6A8;
			5'd1:  a = 32'h1DAC6705;
			5'd2:  a = 32'h0FADBAFC;
			5'd3:  a = 32'h07F56EA6;
			5'd4:  a = 32'h03FEAB76;
			5'd5:  a = 32'h01FFD55B;
			5'd6:  a = 32'h00FFFAAA;
			5'd7:  a = 32'h007FFF55;
			5'd8:  a = 32'h003FFFEA;
			5'd9:  a = 32'h001FFFFD;
			5'd10: a = 32'h000FFFFF;
			5'd11: a = 32'h0007FFFF;
			5'd12: a = 32'h0003FFFF;
			5'd13: a = 32'h0001FFFF;
			5'd14: a = 32'h0000FFFF;
			5'd15: a = 32'h00007FFF;
			5'd16: a = 32'h00003FFF;
			5'd17: a = 32'h00001FFF;
			5'd18: a = 32'h00000FFF;
			5'd19: a = 32'h000007FF;
			5'd20: a = 32'h000003FF;
			5'd21: a = 32'h000001FF;
			5'd22: a = 32'h000000FF;
			5'd23: a = 32'h0000007F;
			5'd24: a = 32'h0000003F;
			5'd25: a = 32'h0000001F;
			5'd26: a = 32'h0000000F;
			5'd27: a = 32'h00000008;
			5'd28: a = 32'h00000004;
			5'd29: a = 32'h00000002;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// shift right by FRAC_BITS, rounding half away from zero
	function automatic logic signed [P_W-1:0] rnd_shr(input logic signed [P_W-1:0] p);
		logic [P_W-1:0] mag;
		logic [P_W-1:0] r;
		mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
		r = (mag + (P_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return p[P_W-1] ? -signed'(r) : signed'(r);
	endfunction

	// Q16 product with rounding
	function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [P_W-1:0] p;
		p = P_W'(a) * P_W'(b);
		return Q_W'(rnd_shr(p));
	endfunction

endpackage

// ----- hdl/sun_direction_vector_core.sv -----
`timescale 1ns / 1ps
// Top level of the sun direction core: input clamps, trig banks, rotation, length and normalize.
// Depends on sdv_pkg, sdv_cordic, sdv_isqrt and sdv_div.

// Takes one request per clock cycle while in_stall is low and returns a unit sun vector (east,
// up, north, signed Q1.16) through two CORDIC sine/cosine pipelines in series (21 stages each),
// an 18-stage square root and an 18-stage divider; the pipeline advances in lockstep and freezes
// while out_stall holds a finished result. Latitude and north offset, set via the configuration
// port, take effect for requests accepted only if written while the pipeline is empty (unchecked).
module sun_direction_vector_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sdv_pkg::TIME_W-1:0]           time_of_day,
	input  logic [sdv_pkg::DAY_W-1:0]            day_num,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sdv_pkg::DIR_W-1:0]     dir_x,
	output logic signed [sdv_pkg::DIR_W-1:0]     dir_y,
	output logic signed [sdv_pkg::DIR_W-1:0]     dir_z,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sdv_pkg::IDX_W-1:0]            cfg_index,
	input  logic [sdv_pkg::NOFF_W-1:0]           cfg_data
);

	localparam int LC   = sdv_pkg::CORDIC_LAT;
	localparam int ISQ  = sdv_pkg::ISQ_LAT;
	localparam int DIV  = sdv_pkg::DIV_LAT;
	localparam int LAST = sdv_pkg::PIPE_LEN - 1;
	localparam int SQ_IDX  = 7 + 2 * LC + ISQ;
	localparam int DIV_IDX = SQ_IDX + DIV;
	localparam int AW = sdv_pkg::ANG_W;
	localparam int QW = sdv_pkg::Q_W;

	localparam logic signed [AW-1:0] NOON_A = AW'(sdv_pkg::NOON_Q16);
	localparam logic signed [AW-1:0] HOUR_A = AW'(sdv_pkg::DEG_PER_HOUR);
	localparam logic signed [AW-1:0] LATM_A = AW'(sdv_pkg::LAT_MAX);
	localparam logic signed [sdv_pkg::P_W-1:0] AMP = sdv_pkg::P_W'(sdv_pkg::DECL_AMP_Q16);
	localparam logic [sdv_pkg::DIR_W-1:0] ONE_D = sdv_pkg::DIR_W'(sdv_pkg::ONE_Q16);
	localparam logic [sdv_pkg::QUO_W-1:0] ONE_Q = sdv_pkg::QUO_W'(sdv_pkg::ONE_Q16);

	// configuration registers
	logic signed [sdv_pkg::LAT_W-1:0]  lat_q;
	logic signed [sdv_pkg::NOFF_W-1:0] noff_q;
	logic signed [AW-1:0]              lat_sat;

	// pipeline control
	logic en;
	logic vld_q [sdv_pkg::PIPE_LEN];

	// front end
	logic [sdv_pkg::TIME_W-1:0]  t_c;
	logic [sdv_pkg::DAY_W-1:0]   d_c;
	logic signed [sdv_pkg::DAY_W:0] n_c;
	logic [sdv_pkg::DAY_W-1:0]   nabs_c;
	logic signed [AW-1:0]        ha_s1;
	logic [AW-1:0]               ymag_s1;
	logic [sdv_pkg::YFX_W-1:0]   yfx_s1;
	logic                        yneg_s1;
	logic [2*sdv_pkg::YFX_W-1:0] yfrac_prod;
	logic [AW-1:0]               ydmag_c;
	logic signed [AW-1:0]        ydeg_s2;
	logic signed [AW-1:0]        ha_dly_q [LC + 2];

	// trig
	logic signed [QW-1:0] sy;
	logic signed [AW-1:0] decl_s3;
	logic signed [QW-1:0] sd, cd, sh, ch, sl, cl, so, co;

	// component math
	logic signed [QW-1:0] cdch_s4, east_s4, p1_s4, p2_s4, sl_s4, cl_s4, so_s4, co_s4;
	logic signed [QW-1:0] up_s5, north_s5, east_s5, so_s5, co_s5;
	logic signed [QW-1:0] wx_s6, up_s6, wz_s6;
	logic signed [2*QW-1:0] sqx_c, sqy_c, sqz_c;
	logic [sdv_pkg::SUM_W-1:0] sqx_s7, sqy_s7, sqz_s7, sum_s8;
	logic signed [QW-1:0] cx_q [ISQ + 2];
	logic signed [QW-1:0] cy_q [ISQ + 2];
	logic signed [QW-1:0] cz_q [ISQ + 2];
	logic [sdv_pkg::LEN_W-1:0] root;
	logic zero_q [DIV];
	sdv_pkg::quo_t qx, qy, qz;
	logic signed [sdv_pkg::DIR_W-1:0] dir_x_s9, dir_y_s9, dir_z_s9;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q  <= '0;
			noff_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sdv_pkg::REG_LATITUDE:     lat_q  <= cfg_data[sdv_pkg::LAT_W-1:0];
				sdv_pkg::REG_NORTH_OFFSET: noff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate latitude at the poles
	always_comb begin
		lat_sat = AW'(lat_q);
		if (lat_sat > LATM_A) lat_sat = LATM_A;
		if (lat_sat < -LATM_A) lat_sat = -LATM_A;
	end

	// advance everything together unless the result register is held
	assign en        = !(vld_q[LAST] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdv_pkg::PIPE_LEN; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < sdv_pkg::PIPE_LEN; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// clamp inputs and split the year angle into whole steps and a remainder
	always_comb begin
		t_c = (time_of_day > sdv_pkg::TIME_W'(sdv_pkg::TIME_MAX))
			? sdv_pkg::TIME_W'(sdv_pkg::TIME_MAX) : time_of_day;
		d_c = day_num;
		if (d_c < sdv_pkg::DAY_W'(1)) d_c = sdv_pkg::DAY_W'(1);
		if (d_c > sdv_pkg::DAY_W'(sdv_pkg::YEAR_DAYS)) d_c = sdv_pkg::DAY_W'(sdv_pkg::YEAR_DAYS);
		n_c = signed'({1'b0, d_c}) - (sdv_pkg::DAY_W+1)'(sdv_pkg::EQUINOX_DAY);
		nabs_c = n_c[sdv_pkg::DAY_W] ? sdv_pkg::DAY_W'(-n_c) : sdv_pkg::DAY_W'(n_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ha_s1   <= (signed'(AW'(t_c)) - NOON_A) * HOUR_A;
			ymag_s1 <= AW'(nabs_c) * AW'(sdv_pkg::YEAR_STEP);
			yfx_s1  <= sdv_pkg::YFX_W'(nabs_c) * sdv_pkg::YFX_W'(sdv_pkg::YEAR_REM)
				+ sdv_pkg::YFX_W'(sdv_pkg::YEAR_DAYS / 2);
			yneg_s1 <= n_c[sdv_pkg::DAY_W];
		end
	end

	// remainder divided by the year length through a reciprocal
	assign yfrac_prod = (2*sdv_pkg::YFX_W)'(yfx_s1)
		* (2*sdv_pkg::YFX_W)'(sdv_pkg::YEAR_RECIP);
	assign ydmag_c = ymag_s1 + AW'(yfrac_prod >> sdv_pkg::RECIP_SH);

	always_ff @(posedge clk) begin
		if (en) begin
			ydeg_s2 <= yneg_s1 ? -signed'(ydmag_c) : signed'(ydmag_c);
		end
	end

	// hold the hour angle until the declination is ready
	always_ff @(posedge clk) begin
		if (en) begin
			ha_dly_q[0] <= ha_s1;
			for (int i = 1; i < LC + 2; i++) ha_dly_q[i] <= ha_dly_q[i-1];
		end
	end

	sdv_cordic u_cordic_year (
		.clk(clk), .en(en), .ang(ydeg_s2), .sin_val(sy), .cos_val()
	);

	// declination in degrees Q16
	always_ff @(posedge clk) begin
		if (en) begin
			decl_s3 <= AW'(sdv_pkg::rnd_shr(AMP * sdv_pkg::P_W'(sy)));
		end
	end

	sdv_cordic u_cordic_decl (
		.clk(clk), .en(en), .ang(decl_s3), .sin_val(sd), .cos_val(cd)
	);
	sdv_cordic u_cordic_hour (
		.clk(clk), .en(en), .ang(ha_dly_q[LC+1]), .sin_val(sh), .cos_val(ch)
	);
	sdv_cordic u_cordic_lat (
		.clk(clk), .en(en), .ang(lat_sat), .sin_val(sl), .cos_val(cl)
	);
	sdv_cordic u_cordic_north (
		.clk(clk), .en(en), .ang(AW'(noff_q)), .sin_val(so), .cos_val(co)
	);

	// local east, up and north
	always_ff @(posedge clk) begin
		if (en) begin
			cdch_s4 <= sdv_pkg::mulq(cd, ch);
			east_s4 <= sdv_pkg::mulq(cd, sh);
			p1_s4   <= sdv_pkg::mulq(sl, sd);
			p2_s4   <= sdv_pkg::mulq(cl, sd);
			sl_s4   <= sl;
			cl_s4   <= cl;
			so_s4   <= so;
			co_s4   <= co;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_s5    <= p1_s4 + sdv_pkg::mulq(cl_s4, cdch_s4);
			north_s5 <= p2_s4 - sdv_pkg::mulq(sl_s4, cdch_s4);
			east_s5  <= east_s4;
			so_s5    <= so_s4;
			co_s5    <= co_s4;
		end
	end

	// rotate about the up axis
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s6 <= sdv_pkg::mulq(co_s5, east_s5) + sdv_pkg::mulq(so_s5, north_s5);
			wz_s6 <= sdv_pkg::mulq(co_s5, north_s5) - sdv_pkg::mulq(so_s5, east_s5);
			up_s6 <= up_s5;
		end
	end

	// squared length
	assign sqx_c = (2*QW)'(wx_s6) * (2*QW)'(wx_s6);
	assign sqy_c = (2*QW)'(up_s6) * (2*QW)'(up_s6);
	assign sqz_c = (2*QW)'(wz_s6) * (2*QW)'(wz_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s7 <= sdv_pkg::SUM_W'(unsigned'(sqx_c));
			sqy_s7 <= sdv_pkg::SUM_W'(unsigned'(sqy_c));
			sqz_s7 <= sdv_pkg::SUM_W'(unsigned'(sqz_c));
			sum_s8 <= sqx_s7 + sqy_s7 + sqz_s7;
		end
	end

	sdv_isqrt u_isqrt (
		.clk(clk), .en(en), .sq(sum_s8), .root(root)
	);

	// hold the components until the length is out
	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= wx_s6;
			cy_q[0] <= up_s6;
			cz_q[0] <= wz_s6;
			for (int i = 1; i < ISQ + 2; i++) begin
				cx_q[i] <= cx_q[i-1];
				cy_q[i] <= cy_q[i-1];
				cz_q[i] <= cz_q[i-1];
			end
		end
	end

	sdv_div u_div_x (.clk(clk), .en(en), .comp(cx_q[ISQ+1]), .len(root), .quo(qx));
	sdv_div u_div_y (.clk(clk), .en(en), .comp(cy_q[ISQ+1]), .len(root), .quo(qy));
	sdv_div u_div_z (.clk(clk), .en(en), .comp(cz_q[ISQ+1]), .len(root), .quo(qz));

	// carry the zero-length flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (root == '0);
			for (int i = 1; i < DIV; i++) zero_q[i] <= zero_q[i-1];
		end
	end

	// saturate, apply sign, substitute straight up for a zero-length vector
	function automatic logic signed [sdv_pkg::DIR_W-1:0] to_dir(input sdv_pkg::quo_t q);
		logic [sdv_pkg::DIR_W-1:0] m;
		m = (q.mag > ONE_Q) ? ONE_D : sdv_pkg::DIR_W'(q.mag);
		return q.neg ? -signed'(m) : signed'(m);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_q[DIV-1]) begin
				dir_x_s9 <= '0;
				dir_y_s9 <= signed'(ONE_D);
				dir_z_s9 <= '0;
			end else begin
				dir_x_s9 <= to_dir(qx);
				dir_y_s9 <= to_dir(qy);
				dir_z_s9 <= to_dir(qz);
			end
		end
	end

	assign dir_x = dir_x_s9;
	assign dir_y = dir_y_s9;
	assign dir_z = dir_z_s9;

	// a zero length can only come from an all-zero vector
	a_zero_len_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[SQ_IDX] && root == '0) |->
			(cx_q[ISQ+1] == '0 && cy_q[ISQ+1] == '0 && cz_q[ISQ+1] == '0))
		else $error("zero length with a nonzero component");

	// rounded quotients never exceed one when the length is valid
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DIV_IDX] && !zero_q[DIV-1]) |->
			(qx.mag <= ONE_Q && qy.mag <= ONE_Q && qz.mag <= ONE_Q))
		else $error("normalized component above one");

	// a zero-length request comes out pointing straight up
	a_zero_up: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DIV_IDX] && zero_q[DIV-1] && en) |=>
			(dir_x == '0 && dir_y == signed'(ONE_D) && dir_z == '0))
		else $error("zero-length request not mapped to the up vector");

endmodule

// ----- hdl/sdv_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined sine/cosine of an angle in degrees Q16: range fold, radian scaling, CORDIC stages.
// Depends on sdv_pkg.
module sdv_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [sdv_pkg::ANG_W-1:0]    ang,
	output logic signed [sdv_pkg::Q_W-1:0]      sin_val,
	output logic signed [sdv_pkg::Q_W-1:0]      cos_val
);

	localparam logic signed [sdv_pkg::ANG_W-1:0] FT = sdv_pkg::ANG_W'(sdv_pkg::FULL_TURN_Q16);
	localparam logic signed [sdv_pkg::ANG_W-1:0] HT = sdv_pkg::ANG_W'(sdv_pkg::HALF_TURN_Q16);
	localparam logic signed [sdv_pkg::ANG_W-1:0] QT =
		sdv_pkg::ANG_W'(sdv_pkg::QUARTER_TURN_Q16);
	localparam logic signed [sdv_pkg::P_W-1:0] D2R = sdv_pkg::P_W'(sdv_pkg::DEG_TO_RAD_Q30);
	localparam logic signed [sdv_pkg::Q_W-1:0] GAIN = sdv_pkg::Q_W'(sdv_pkg::GAIN_Q);
	localparam int N = sdv_pkg::CORDIC_STEPS;

	logic signed [sdv_pkg::ANG_W-1:0] red_c;
	logic                             flip_c;
	logic signed [sdv_pkg::ANG_W-1:0] red_s1;
	logic                             flip_s1;
	logic signed [sdv_pkg::Z_W-1:0]   z_s2;
	logic                             flip_s2;
	logic signed [sdv_pkg::P_W-1:0]   rad_prod;

	logic signed [sdv_pkg::Q_W-1:0] x_q [N];
	logic signed [sdv_pkg::Q_W-1:0] y_q [N];
	logic signed [sdv_pkg::Z_W-1:0] z_q [N];
	logic                           f_q [N];

	// wrap into half turns, then fold into plus or minus a quarter turn
	always_comb begin
		red_c = ang;
		if (red_c >= HT) red_c = red_c - FT;
		if (red_c >= HT) red_c = red_c - FT;
		if (red_c < -HT) red_c = red_c + FT;
		if (red_c < -HT) red_c = red_c + FT;
		flip_c = 1'b0;
		if (red_c > QT) begin
			red_c = red_c - HT;
			flip_c = 1'b1;
		end else if (red_c < -QT) begin
			red_c = red_c + HT;
			flip_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1  <= red_c;
			flip_s1 <= flip_c;
		end
	end

	// scale degrees to radians Q30
	assign rad_prod = sdv_pkg::P_W'(red_s1) * D2R;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2    <= sdv_pkg::Z_W'(sdv_pkg::rnd_shr(rad_prod));
			flip_s2 <= flip_s1;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		logic signed [sdv_pkg::Q_W-1:0] x_in;
		logic signed [sdv_pkg::Q_W-1:0] y_in;
		logic signed [sdv_pkg::Z_W-1:0] z_in;
		logic                           f_in;
		logic signed [sdv_pkg::Z_W-1:0] at;

		if (k == 0) begin : g_first
			assign x_in = GAIN;
			assign y_in = '0;
			assign z_in = z_s2;
			assign f_in = flip_s2;
		end else begin : g_next
			assign x_in = x_q[k-1];
			assign y_in = y_q[k-1];
			assign z_in = z_q[k-1];
			assign f_in = f_q[k-1];
		end

		assign at = signed'(sdv_pkg::Z_W'(sdv_pkg::atan_q30(5'(k))));

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_in >= 0) begin
					x_q[k] <= x_in - (y_in >>> k);
					y_q[k] <= y_in + (x_in >>> k);
					z_q[k] <= z_in - at;
				end else begin
					x_q[k] <= x_in + (y_in >>> k);
					y_q[k] <= y_in - (x_in >>> k);
					z_q[k] <= z_in + at;
				end
				f_q[k] <= f_in;
			end
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= f_q[N-1] ? -y_q[N-1] : y_q[N-1];
			cos_val <= f_q[N-1] ? -x_q[N-1] : x_q[N-1];
		end
	end

endmodule

// ----- hdl/sdv_isqrt.sv -----
`timescale 1ns / 1ps
// Pipelined floor integer square root, one result bit per stage.
// Depends on sdv_pkg.
module sdv_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sdv_pkg::SUM_W-1:0]   sq,
	output logic [sdv_pkg::LEN_W-1:0]   root
);

	localparam int N = sdv_pkg::ISQ_STEPS;

	logic [sdv_pkg::SUM_W-1:0] v_q [N];
	logic [sdv_pkg::SUM_W-1:0] r_q [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [sdv_pkg::SUM_W-1:0] BIT = sdv_pkg::SUM_W'(1) << (2 * (N - 1 - k));
		logic [sdv_pkg::SUM_W-1:0] v_in;
		logic [sdv_pkg::SUM_W-1:0] r_in;
		logic [sdv_pkg::SUM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in = sq;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_q[k-1];
			assign r_in = r_q[k-1];
		end

		assign trial = r_in + BIT;

		// subtract the trial when it fits, then advance the root
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_q[k] <= v_in - trial;
					r_q[k] <= (r_in >> 1) + BIT;
				end else begin
					v_q[k] <= v_in;
					r_q[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = sdv_pkg::LEN_W'(r_q[N-1]);

endmodule

// ----- hdl/sdv_div.sv -----
`timescale 1ns / 1ps
// Pipelined rounded division of a Q16 component by the vector length, one quotient bit per stage.
// Depends on sdv_pkg.
module sdv_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [sdv_pkg::Q_W-1:0]   comp,
	input  logic [sdv_pkg::LEN_W-1:0]        len,
	output sdv_pkg::quo_t                    quo
);

	localparam int N = sdv_pkg::DIV_STEPS;

	logic [sdv_pkg::Q_W-1:0]   mag_c;
	logic [sdv_pkg::SUM_W-1:0] rem_s0;
	logic [sdv_pkg::LEN_W-1:0] den_s0;
	logic                      neg_s0;

	logic [sdv_pkg::SUM_W-1:0] rem_q [N];
	logic [sdv_pkg::LEN_W-1:0] den_q [N];
	logic [sdv_pkg::QUO_W-1:0] q_q   [N];
	logic                      neg_q [N];

	assign mag_c = comp[sdv_pkg::Q_W-1] ? sdv_pkg::Q_W'(-comp) : sdv_pkg::Q_W'(comp);

	// scale the magnitude and add half the divisor for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s0 <= (sdv_pkg::SUM_W'(mag_c) << sdv_pkg::FRAC_BITS)
				+ sdv_pkg::SUM_W'(len >> 1);
			den_s0 <= len;
			neg_s0 <= comp[sdv_pkg::Q_W-1];
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int SH = N - 1 - k;
		logic [sdv_pkg::SUM_W-1:0] rem_in;
		logic [sdv_pkg::LEN_W-1:0] den_in;
		logic [sdv_pkg::QUO_W-1:0] q_in;
		logic                      neg_in;
		logic [sdv_pkg::SUM_W-1:0] sub;

		if (k == 0) begin : g_first
			assign rem_in = rem_s0;
			assign den_in = den_s0;
			assign q_in   = '0;
			assign neg_in = neg_s0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign q_in   = q_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		assign sub = sdv_pkg::SUM_W'(den_in) << SH;

		// compare and subtract the shifted divisor
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= sub) begin
					rem_q[k] <= rem_in - sub;
					q_q[k]   <= q_in | (sdv_pkg::QUO_W'(1) << SH);
				end else begin
					rem_q[k] <= rem_in;
					q_q[k]   <= q_in;
				end
				den_q[k] <= den_in;
				neg_q[k] <= neg_in;
			end
		end
	end

	assign quo.neg = neg_q[N-1];
	assign quo.mag = q_q[N-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sun_direction_vector_core: random and directed time/day requests,
// several latitude and north offset settings, a fixed-point sun vector predictor per request.
// Depends on sdv_pkg and the sun_direction_vector_core RTL.

// Expected sun vectors of accepted requests, with its own copy of the two registers
class sun_vector_board;
	typedef struct {
		logic signed [sdv_pkg::DIR_W-1:0] x, y, z;
	} sun_vec_t;

	sun_vec_t want_q[$];
	longint   lat_deg;
	longint   north_deg;
	int       errors;
	longint   atan_rad[18] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF
	};

	function void clear_regs();
		lat_deg = 0;
		north_deg = 0;
	endfunction

	function void write_reg(logic [sdv_pkg::IDX_W-1:0] idx, logic [sdv_pkg::NOFF_W-1:0] data);
		logic signed [sdv_pkg::LAT_W-1:0] lat_bits;
		logic signed [sdv_pkg::NOFF_W-1:0] off_bits;
		lat_bits = data[sdv_pkg::LAT_W-1:0];
		off_bits = data;
		if (idx == sdv_pkg::REG_LATITUDE)
			lat_deg = lat_bits;
		else if (idx == sdv_pkg::REG_NORTH_OFFSET)
			north_deg = off_bits;
	endfunction

	// shift right, rounding half away from zero
	function longint round_shift(longint v, int s);
		longint mag, r;
		mag = v < 0 ? -v : v;
		r = (mag + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -r : r;
	endfunction

	function longint round_quot(longint n, longint d);
		longint mag, r;
		mag = n < 0 ? -n : n;
		r = (mag + d / 2) / d;
		return n < 0 ? -r : r;
	endfunction

	function longint qmul(longint a, longint b);
		return round_shift(a * b, sdv_pkg::FRAC_BITS);
	endfunction

	// CORDIC sine and cosine of an angle in degrees Q16
	function void sin_cos(longint deg, output longint s, output longint c);
		longint r, x, y, z, dx, dy, nx;
		bit flip;
		flip = 0;
		r = deg % sdv_pkg::FULL_TURN_Q16;
		if (r < 0) r += sdv_pkg::FULL_TURN_Q16;
		if (r >= sdv_pkg::HALF_TURN_Q16) r -= sdv_pkg::FULL_TURN_Q16;
		if (r > sdv_pkg::QUARTER_TURN_Q16) begin
			r -= sdv_pkg::HALF_TURN_Q16;
			flip = 1;
		end else if (r < -sdv_pkg::QUARTER_TURN_Q16) begin
			r += sdv_pkg::HALF_TURN_Q16;
			flip = 1;
		end
		z = round_shift(r * sdv_pkg::DEG_TO_RAD_Q30, 16);
		x = round_shift(sdv_pkg::GAIN_Q30, 30 - sdv_pkg::FRAC_BITS);
		y = 0;
		for (int i = 0; i < sdv_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				nx = x - dx;
				y = y + dy;
				z -= atan_rad[i];
			end else begin
				nx = x + dx;
				y = y - dy;
				z += atan_rad[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function longint floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function longint unit_comp(longint comp, longint len);
		longint v;
		v = round_quot(comp * sdv_pkg::ONE_Q16, len);
		if (v > sdv_pkg::ONE_Q16) v = sdv_pkg::ONE_Q16;
		if (v < -sdv_pkg::ONE_Q16) v = -sdv_pkg::ONE_Q16;
		return v;
	endfunction

	// predict the sun vector of one accepted request
	function void note_request(logic [sdv_pkg::TIME_W-1:0] tod, logic [sdv_pkg::DAY_W-1:0] doy);
		longint t, d, lat, year_ang, decl, ha;
		longint sy, cy, sd, cd, sh, ch, sl, cl, so, co, cdch;
		longint east, up, north, wx, wz, len;
		sun_vec_t v;
		t = tod;
		d = doy;
		lat = lat_deg;
		if (t > sdv_pkg::TIME_MAX) t = sdv_pkg::TIME_MAX;
		if (d < 1) d = 1;
		if (d > sdv_pkg::YEAR_DAYS) d = sdv_pkg::YEAR_DAYS;
		if (lat > sdv_pkg::LAT_MAX) lat = sdv_pkg::LAT_MAX;
		if (lat < -sdv_pkg::LAT_MAX) lat = -sdv_pkg::LAT_MAX;
		year_ang = round_quot((d - sdv_pkg::EQUINOX_DAY) * sdv_pkg::FULL_TURN_Q16,
			sdv_pkg::YEAR_DAYS);
		sin_cos(year_ang, sy, cy);
		decl = round_shift(sdv_pkg::DECL_AMP_Q16 * sy, sdv_pkg::FRAC_BITS);
		ha = (t - sdv_pkg::NOON_Q16) * sdv_pkg::DEG_PER_HOUR;
		sin_cos(decl, sd, cd);
		sin_cos(ha, sh, ch);
		sin_cos(lat, sl, cl);
		sin_cos(north_deg, so, co);
		cdch = qmul(cd, ch);
		east = qmul(cd, sh);
		up = qmul(sl, sd) + qmul(cl, cdch);
		north = qmul(cl, sd) - qmul(sl, cdch);
		wx = qmul(co, east) + qmul(so, north);
		wz = qmul(co, north) - qmul(so, east);
		len = floor_sqrt(wx * wx + up * up + wz * wz);
		if (len == 0) begin
			v.x = 0;
			v.y = sdv_pkg::ONE_Q16;
			v.z = 0;
		end else begin
			v.x = unit_comp(wx, len);
			v.y = unit_comp(up, len);
			v.z = unit_comp(wz, len);
		end
		want_q.insert(want_q.size(), v);
	endfunction

	function void check_result(logic signed [sdv_pkg::DIR_W-1:0] x, y, z);
		sun_vec_t w;
		if (want_q.size() == 0) begin
			$display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x, y, z);
			errors++;
			return;
		end
		w = want_q.pop_front();
		if (x !== w.x) begin
			$display("%0t: dir_x expected %0d actual %0d", $time, w.x, x);
			errors++;
		end
		if (y !== w.y) begin
			$display("%0t: dir_y expected %0d actual %0d", $time, w.y, y);
			errors++;
		end
		if (z !== w.z) begin
			$display("%0t: dir_z expected %0d actual %0d", $time, w.z, z);
			errors++;
		end
	endfunction
endclass

module tb_top;

	localparam logic [sdv_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 120;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [sdv_pkg::TIME_W-1:0]        time_of_day;
	logic [sdv_pkg::DAY_W-1:0]         day_num;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [sdv_pkg::DIR_W-1:0]  dir_x, dir_y, dir_z;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [sdv_pkg::IDX_W-1:0]         cfg_index;
	logic [sdv_pkg::NOFF_W-1:0]        cfg_data;

	sun_vector_board board;
	int  idle_pct;
	bit  hold_req;
	int  hold_cnt;
	int  cycles;

	sun_direction_vector_core uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// drive the result stall: random idling, or one long hold-off when asked
	initial begin
		out_stall = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall = 1;
			end else
				out_stall = idle_pct != 0 && $urandom_range(99) < idle_pct;
		end
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(dir_x, dir_y, dir_z);
	end

	// offer one request, with random idle cycles before it, and hold it until accepted
	task automatic send_request(logic [sdv_pkg::TIME_W-1:0] t, logic [sdv_pkg::DAY_W-1:0] d);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		time_of_day = t;
		day_num = d;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		board.note_request(t, d);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (board.want_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [sdv_pkg::IDX_W-1:0] idx, logic [sdv_pkg::NOFF_W-1:0] data);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_requests(int n);
		logic [sdv_pkg::TIME_W-1:0] t;
		logic [sdv_pkg::DAY_W-1:0] d;
		for (int i = 0; i < n; i++) begin
			// mostly valid times and days, some out of range
			t = ($urandom_range(9) == 0)
				? sdv_pkg::TIME_W'($urandom_range((1 << sdv_pkg::TIME_W) - 1))
				: sdv_pkg::TIME_W'($urandom_range(sdv_pkg::TIME_MAX));
			d = ($urandom_range(7) == 0)
				? sdv_pkg::DAY_W'($urandom_range((1 << sdv_pkg::DAY_W) - 1))
				: sdv_pkg::DAY_W'($urandom_range(1, sdv_pkg::YEAR_DAYS));
			send_request(t, d);
		end
	endtask

	logic [sdv_pkg::TIME_W-1:0] dir_times[5] = '{sdv_pkg::TIME_W'(0),
		sdv_pkg::TIME_W'(sdv_pkg::TIME_MAX), sdv_pkg::TIME_W'((1 << sdv_pkg::TIME_W) - 1),
		sdv_pkg::TIME_W'(sdv_pkg::NOON_Q16), sdv_pkg::TIME_W'(6 * sdv_pkg::ONE_Q16)};
	logic [sdv_pkg::DAY_W-1:0]  dir_days[5]  = '{sdv_pkg::DAY_W'(0), sdv_pkg::DAY_W'(1),
		sdv_pkg::DAY_W'(sdv_pkg::EQUINOX_DAY), sdv_pkg::DAY_W'(sdv_pkg::YEAR_DAYS),
		sdv_pkg::DAY_W'((1 << sdv_pkg::DAY_W) - 1)};
	logic [sdv_pkg::NOFF_W-1:0] lat_set[5];
	logic [sdv_pkg::NOFF_W-1:0] off_set[5];

	initial begin
		board = new();
		board.clear_regs();
		idle_pct = 0;
		hold_req = 0;
		arst_n = 0;
		in_valid = 0;
		time_of_day = 0;
		day_num = 0;
		cfg_valid = 0;
		cfg_index = sdv_pkg::REG_LATITUDE;
		cfg_data = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// directed: field extremes and special cases, registers at reset
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				send_request(dir_times[i], dir_days[j]);
		drain();

		// settings: poles, beyond the poles, offset extremes, random raw values
		lat_set = '{sdv_pkg::NOFF_W'(sdv_pkg::LAT_MAX), sdv_pkg::NOFF_W'(-sdv_pkg::LAT_MAX),
			26'h07FFFFF, 26'h0800000,
			sdv_pkg::NOFF_W'($urandom_range((1 << sdv_pkg::NOFF_W) - 1))};
		off_set = '{sdv_pkg::NOFF_W'(sdv_pkg::FULL_TURN_Q16),
			sdv_pkg::NOFF_W'(-sdv_pkg::FULL_TURN_Q16), 26'h1FFFFFF, 26'h2000000,
			sdv_pkg::NOFF_W'($urandom_range((1 << sdv_pkg::NOFF_W) - 1))};
		for (int p = 0; p < 6; p++) begin
			if (p < 5) begin
				write_reg(sdv_pkg::REG_LATITUDE, lat_set[p]);
				write_reg(sdv_pkg::REG_NORTH_OFFSET, off_set[p]);
			end else begin
				write_reg(sdv_pkg::REG_LATITUDE, sdv_pkg::NOFF_W'(
					$urandom_range(2 * sdv_pkg::LAT_MAX) - sdv_pkg::LAT_MAX));
				write_reg(sdv_pkg::REG_NORTH_OFFSET, sdv_pkg::NOFF_W'(
					$urandom_range(2 * sdv_pkg::FULL_TURN_Q16) - sdv_pkg::FULL_TURN_Q16));
			end
			// unknown index must leave both registers alone
			write_reg(REG_SPARE, sdv_pkg::NOFF_W'($urandom_range((1 << sdv_pkg::NOFF_W) - 1)));
			idle_pct = 24;
			if (p == 1) hold_req = 1;
			random_requests(160);
			// stretch with no idling on either side
			idle_pct = 0;
			random_requests(70);
			drain();
		end

		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
